[rtl/lbba_pkg.sv]
// ----------------------------------------------------------------------------
// lbba_pkg: shared definitions for the low battery beep alarm
// Register indexes, field widths and reset values of the configuration.
// ----------------------------------------------------------------------------
package lbba_pkg;

  // Field widths
  localparam int unsigned MvW      = 14;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned HalfW    = 15;
  localparam int unsigned ToneW    = 4;
  localparam int unsigned PrescW   = 8;
  localparam int unsigned PatternW = 16;
  localparam int unsigned MillisW  = 32;

  // Stream and configuration port widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegLowThreshold = 3'd0,
    RegLowHold      = 3'd1,
    RegBeepHalf     = 3'd2,
    RegToneDivide   = 3'd3,
    RegTicksPerMs   = 3'd4
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [MvW-1:0]    LowThresholdRst = 14'd6400;
  localparam logic [HoldW-1:0]  LowHoldRst      = 16'd5000;
  localparam logic [HalfW-1:0]  BeepHalfRst     = 15'd5000;
  localparam logic [ToneW-1:0]  ToneDivideRst   = 4'd2;
  localparam logic [PrescW-1:0] TicksPerMsRst   = 8'd10;

  // Saturation value of the low-voltage hold counter
  localparam logic [HoldW-1:0] HoldMax = {HoldW{1'b1}};

endpackage

[rtl/low_battery_beep_alarm.sv]
// ----------------------------------------------------------------------------
// low_battery_beep_alarm: buzzer alarm for a low battery voltage
// Tick-driven tone generator, beep pattern, millisecond counter and
// low-voltage hold timer with alarm set and clear.
// ----------------------------------------------------------------------------
// Each input request is one base tick (nominally 100 us) and yields exactly
// one result request. All counters update from a single pass of compare and
// increment logic into the state registers and the output register, so one
// tick can be accepted in every cycle as long as the result side keeps up;
// the output register lets a new tick in while the previous result is being
// taken. The buzzer toggles every tone_divide ticks while the beep gate (as
// left by the previous tick) is on; with the alarm set, the gate is on for
// beep_half_ticks - 1 of every 2 * beep_half_ticks ticks. The alarm sets
// after the battery stays below low_threshold_mv for more than low_hold_ms
// milliseconds, or on force_alarm, and clears on a good voltage unless
// manual_hold is set. Configuration is taken at any time via the cfg
// channel, which is always ready; write it only while no tick is in flight.
module low_battery_beep_alarm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lbba_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lbba_pkg::CfgDataW-1:0]       cfg_data_i,
  // Tick input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [13:0] battery_mv, [14] manual_hold, [15] force_alarm
  input  logic [lbba_pkg::InDataW-1:0]        s_axis_tdata_i,
  // Result output stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [0] buzzer_level, [1] alarm_active, [33:2] ms_count, [39:34] zero
  output logic [lbba_pkg::OutDataW-1:0]       m_axis_tdata_o
);

  // Configuration registers
  logic [lbba_pkg::MvW-1:0]    low_thr_q;
  logic [lbba_pkg::HoldW-1:0]  low_hold_q;
  logic [lbba_pkg::HalfW-1:0]  beep_half_q;
  logic [lbba_pkg::ToneW-1:0]  tone_div_q;
  logic [lbba_pkg::PrescW-1:0] ticks_ms_q;

  // Tick state
  logic                           pin_q, pin_d;
  logic [lbba_pkg::ToneW-1:0]     tone_cnt_q, tone_cnt_d;
  logic                           gate_q, gate_d;
  logic [lbba_pkg::PatternW-1:0]  pat_cnt_q, pat_cnt_d;
  logic                           alarm_q, alarm_d;
  logic [lbba_pkg::PrescW-1:0]    presc_q, presc_d;
  logic [lbba_pkg::MillisW-1:0]   millis_q, millis_d;
  logic [lbba_pkg::HoldW-1:0]     low_time_q, low_time_d;

  // Output register
  logic                           out_valid_q;
  logic [lbba_pkg::OutDataW-1:0]  out_data_q;

  // Input fields
  logic [lbba_pkg::MvW-1:0] mv;
  logic                     manual;
  logic                     force_req;
  logic                     in_fire;

  // Intermediate sums
  logic [lbba_pkg::ToneW:0]      tone_inc;
  logic [lbba_pkg::PatternW:0]   pat_inc;
  logic [lbba_pkg::PatternW:0]   half_ext;
  logic [lbba_pkg::PatternW:0]   period_ext;
  logic [lbba_pkg::PrescW:0]     presc_inc;
  logic                          alarm_pre;

  assign mv        = s_axis_tdata_i[lbba_pkg::MvW-1:0];
  assign manual    = s_axis_tdata_i[lbba_pkg::MvW];
  assign force_req = s_axis_tdata_i[lbba_pkg::MvW+1];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign tone_inc   = {1'b0, tone_cnt_q} + 1'b1;
  assign pat_inc    = {1'b0, pat_cnt_q} + 1'b1;
  assign half_ext   = {2'b00, beep_half_q};
  assign period_ext = {1'b0, beep_half_q, 1'b0};
  assign presc_inc  = {1'b0, presc_q} + 1'b1;

  // Next tick state
  always_comb begin
    pin_d      = pin_q;
    tone_cnt_d = tone_cnt_q;
    gate_d     = gate_q;
    pat_cnt_d  = pat_cnt_q;
    presc_d    = presc_q;
    millis_d   = millis_q;
    low_time_d = low_time_q;

    alarm_pre = alarm_q || force_req;

    // Tone divider, driven by the gate of the previous tick
    if (gate_q) begin
      if (tone_inc >= {1'b0, tone_div_q}) begin
        tone_cnt_d = '0;
        pin_d      = !pin_q;
      end else begin
        tone_cnt_d = tone_inc[lbba_pkg::ToneW-1:0];
      end
    end else begin
      pin_d = 1'b0;
    end

    // Beep on/off pattern; the gate holds on the wrap tick
    if (!alarm_pre) begin
      gate_d    = 1'b0;
      pat_cnt_d = '0;
    end else if (pat_inc < half_ext) begin
      gate_d    = 1'b1;
      pat_cnt_d = pat_inc[lbba_pkg::PatternW-1:0];
    end else if (pat_inc < period_ext) begin
      gate_d    = 1'b0;
      pat_cnt_d = pat_inc[lbba_pkg::PatternW-1:0];
    end else begin
      pat_cnt_d = '0;
    end

    // Millisecond step and low-voltage hold timer
    alarm_d = alarm_pre;
    if (presc_inc >= {1'b0, ticks_ms_q}) begin
      presc_d  = '0;
      millis_d = millis_q + 1'b1;
      if (mv < low_thr_q) begin
        if (low_time_q != lbba_pkg::HoldMax) begin
          low_time_d = low_time_q + 1'b1;
        end
        if (low_time_d > low_hold_q) begin
          alarm_d = 1'b1;
        end
      end else begin
        low_time_d = '0;
        if (!manual) begin
          alarm_d = 1'b0;
        end
      end
    end else begin
      presc_d = presc_inc[lbba_pkg::PrescW-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q   <= lbba_pkg::LowThresholdRst;
      low_hold_q  <= lbba_pkg::LowHoldRst;
      beep_half_q <= lbba_pkg::BeepHalfRst;
      tone_div_q  <= lbba_pkg::ToneDivideRst;
      ticks_ms_q  <= lbba_pkg::TicksPerMsRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lbba_pkg::RegLowThreshold: low_thr_q   <= cfg_data_i[lbba_pkg::MvW-1:0];
        lbba_pkg::RegLowHold:      low_hold_q  <= cfg_data_i[lbba_pkg::HoldW-1:0];
        lbba_pkg::RegBeepHalf:     beep_half_q <= cfg_data_i[lbba_pkg::HalfW-1:0];
        lbba_pkg::RegToneDivide:   tone_div_q  <= cfg_data_i[lbba_pkg::ToneW-1:0];
        lbba_pkg::RegTicksPerMs:   ticks_ms_q  <= cfg_data_i[lbba_pkg::PrescW-1:0];
        default: ;
      endcase
    end
  end

  // Tick state update on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q      <= 1'b0;
      tone_cnt_q <= '0;
      gate_q     <= 1'b0;
      pat_cnt_q  <= '0;
      alarm_q    <= 1'b0;
      presc_q    <= '0;
      millis_q   <= '0;
      low_time_q <= '0;
    end else if (in_fire) begin
      pin_q      <= pin_d;
      tone_cnt_q <= tone_cnt_d;
      gate_q     <= gate_d;
      pat_cnt_q  <= pat_cnt_d;
      alarm_q    <= alarm_d;
      presc_q    <= presc_d;
      millis_q   <= millis_d;
      low_time_q <= low_time_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {6'b000000, millis_d, alarm_d, pin_d};
    end
  end

endmodule

[tb/tb_low_battery_beep_alarm.sv]
// ----------------------------------------------------------------------------
// tb_low_battery_beep_alarm: self-checking bench for the low battery alarm
// Drives tick requests and register writes, predicts every result request
// from a cycle-free model of the buzzer, pattern, prescaler and hold timer,
// and compares each result field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_low_battery_beep_alarm;
  import lbba_pkg::*;

  localparam int unsigned StallLimit    = 2000;  // cycles without any handshake
  localparam int unsigned HoldoffCycles = 300;   // long result-side hold-off
  localparam int unsigned MaxReports    = 20;

  typedef struct {
    logic               buzzer;
    logic               alarm;
    logic [MillisW-1:0] ms;
  } beep_result_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // DUT ports; the driven inputs are known from time zero
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                m_axis_tvalid_o;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  low_battery_beep_alarm dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Mirror of the configuration registers
  logic [MvW-1:0]    cfg_threshold    = LowThresholdRst;
  logic [HoldW-1:0]  cfg_hold_ms      = LowHoldRst;
  logic [HalfW-1:0]  cfg_beep_half    = BeepHalfRst;
  logic [ToneW-1:0]  cfg_tone_div     = ToneDivideRst;
  logic [PrescW-1:0] cfg_ticks_per_ms = TicksPerMsRst;

  // Predicted alarm state
  logic                exp_pin         = 1'b0;
  logic [ToneW-1:0]    exp_tone_cnt    = '0;
  logic                exp_gate        = 1'b0;
  logic [PatternW-1:0] exp_pattern_cnt = '0;
  logic                exp_alarm       = 1'b0;
  logic [PrescW-1:0]   exp_prescale    = '0;
  logic [MillisW-1:0]  exp_millis      = '0;
  logic [HoldW-1:0]    exp_low_ms      = '0;

  beep_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  idle_cycles = 0;

  // Stall controls
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned holdoff_req  = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;

  // One tick: buzzer stage on the old gate, pattern stage, then the ms stage
  function automatic beep_result_t advance_alarm_tick(input logic [MvW-1:0] mv,
                                                       input logic manual,
                                                       input logic force_req);
    int unsigned  t;
    beep_result_t r;
    if (force_req) exp_alarm = 1'b1;

    if (exp_gate) begin
      t = 32'(exp_tone_cnt) + 1;
      if (t >= 32'(cfg_tone_div)) begin
        exp_tone_cnt = '0;
        exp_pin      = ~exp_pin;
      end else begin
        exp_tone_cnt = t[ToneW-1:0];
      end
    end else begin
      exp_pin = 1'b0;
    end

    // Pattern: on while count + 1 < half, else off; wrap keeps the gate
    if (!exp_alarm) begin
      exp_gate        = 1'b0;
      exp_pattern_cnt = '0;
    end else begin
      t = 32'(exp_pattern_cnt) + 1;
      if (t < 32'(cfg_beep_half)) begin
        exp_gate        = 1'b1;
        exp_pattern_cnt = t[PatternW-1:0];
      end else if (t < 2 * 32'(cfg_beep_half)) begin
        exp_gate        = 1'b0;
        exp_pattern_cnt = t[PatternW-1:0];
      end else begin
        exp_pattern_cnt = '0;
      end
    end

    // Millisecond step with the saturating low-voltage timer
    t = 32'(exp_prescale) + 1;
    if (t >= 32'(cfg_ticks_per_ms)) begin
      exp_prescale = '0;
      exp_millis   = exp_millis + 1'b1;
      if (mv < cfg_threshold) begin
        if (exp_low_ms != HoldMax) exp_low_ms = exp_low_ms + 1'b1;
        if (exp_low_ms > cfg_hold_ms) exp_alarm = 1'b1;
      end else begin
        exp_low_ms = '0;
        if (!manual) exp_alarm = 1'b0;
      end
    end else begin
      exp_prescale = t[PrescW-1:0];
    end

    r.buzzer = exp_pin;
    r.alarm  = exp_alarm;
    r.ms     = exp_millis;
    return r;
  endfunction

  // Handshake monitor: register writes, result checks, tick predictions
  always @(posedge clk_i) begin
    beep_result_t want;
    logic         busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready_o) begin
        busy = 1'b1;
        case (cfg_index)
          RegLowThreshold: cfg_threshold    = cfg_data[MvW-1:0];
          RegLowHold:      cfg_hold_ms      = cfg_data[HoldW-1:0];
          RegBeepHalf:     cfg_beep_half    = cfg_data[HalfW-1:0];
          RegToneDivide:   cfg_tone_div     = cfg_data[ToneW-1:0];
          RegTicksPerMs:   cfg_ticks_per_ms = cfg_data[PrescW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_o && m_tready) begin
        busy = 1'b1;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: result with no tick pending: expected none, actual %h",
                     $time, m_axis_tdata_o);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata_o[0] !== want.buzzer) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: buzzer_level expected %0d actual %0d",
                       $time, want.buzzer, m_axis_tdata_o[0]);
          end
          if (m_axis_tdata_o[1] !== want.alarm) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: alarm_active expected %0d actual %0d",
                       $time, want.alarm, m_axis_tdata_o[1]);
          end
          if (m_axis_tdata_o[33:2] !== want.ms) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: ms_count expected %0d actual %0d",
                       $time, want.ms, m_axis_tdata_o[33:2]);
          end
        end
      end
      if (s_tvalid && s_axis_tready_o) begin
        busy = 1'b1;
        pending_results.push_back(advance_alarm_tick(s_tdata[MvW-1:0], s_tdata[MvW],
                                                     s_tdata[MvW+1]));
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  // Result-side ready with random stalls and an occasional long hold-off
  always @(negedge clk_i) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HoldoffCycles;
    end
    if (holdoff_left > 0) begin
      m_tready = 1'b0;
      holdoff_left--;
    end else begin
      m_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake at all
  initial begin
    wait (rst_ni);
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // Send one tick request; called and returns just after a falling edge
  task automatic send_tick(input logic [MvW-1:0] mv, input logic manual,
                           input logic force_req);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tdata  = {force_req, manual, mv};
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Drain all results, let the output stage settle, resume at a falling edge
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Voltage on either side of the current threshold
  function automatic logic [MvW-1:0] pick_mv(input bit low);
    if (!low) return MvW'($urandom_range(16383, cfg_threshold));
    if (cfg_threshold == 0) return MvW'($urandom);
    return MvW'($urandom_range(cfg_threshold - 1, 0));
  endfunction

  // Short timings so that alarms set, beep and clear within a few hundred ticks
  task automatic write_random_config();
    write_reg(RegLowThreshold, CfgDataW'($urandom_range(16383, 1)));
    write_reg(RegLowHold, CfgDataW'($urandom_range(20, 0)));
    write_reg(RegBeepHalf, CfgDataW'($urandom_range(8, 1)));
    if ($urandom_range(3) == 0) write_reg(RegToneDivide, CfgDataW'($urandom_range(15, 1)));
    else write_reg(RegToneDivide, CfgDataW'($urandom_range(4, 1)));
    write_reg(RegTicksPerMs, CfgDataW'($urandom_range(4, 1)));
  endtask

  // Reset values, extremes of every input field, forced alarm
  task automatic test_reset_values();
    send_tick(14'd0, 1'b0, 1'b0);
    send_tick(14'd16383, 1'b0, 1'b0);
    send_tick(14'd6399, 1'b1, 1'b1);
    send_tick(14'd6400, 1'b1, 1'b0);
    send_tick(14'd6400, 1'b0, 1'b0);
  endtask

  // Tone divide of zero, ms step on every tick, pattern wrap, zero hold
  task automatic test_tone_and_pattern_corners();
    wait_idle();
    write_reg(RegLowThreshold, 16'd16383);
    write_reg(RegLowHold, 16'd0);
    write_reg(RegBeepHalf, 16'd2);
    write_reg(RegToneDivide, 16'd0);
    write_reg(RegTicksPerMs, 16'd0);
    send_tick(14'd0, 1'b0, 1'b1);
    repeat (6) send_tick(14'd0, 1'b0, 1'b0);
  endtask

  // Beep half of zero holds the gate; good voltage clears unless manual
  task automatic test_beep_half_zero();
    wait_idle();
    write_reg(RegBeepHalf, 16'd0);
    repeat (4) send_tick(14'd16383, 1'b1, 1'b0);
    send_tick(14'd16383, 1'b0, 1'b0);
    send_tick(14'd16383, 1'b0, 1'b0);
  endtask

  // Top hold value keeps a low stretch quiet; a zero hold trips at once
  task automatic test_hold_saturation();
    wait_idle();
    write_reg(RegLowThreshold, 16'd16383);
    write_reg(RegLowHold, 16'hFFFF);
    write_reg(RegTicksPerMs, 16'd0);
    write_reg(RegToneDivide, 16'd3);
    send_tick(14'd16383, 1'b0, 1'b0);
    repeat (30) send_tick(14'd0, 1'b0, 1'b0);
    wait_idle();
    write_reg(RegLowHold, 16'd0);
    repeat (3) send_tick(14'd0, 1'b0, 1'b0);
    send_tick(14'd16383, 1'b0, 1'b0);
  endtask

  // Random low/good voltage episodes under the given stall rates
  task automatic test_random_phase(input int unsigned n_items,
                                   input int unsigned tx_idle,
                                   input int unsigned rx_stall);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    logic        manual;
    tx_idle_pct  = tx_idle;
    rx_stall_pct = rx_stall;
    repeat (2) begin
      wait_idle();
      write_random_config();
      sent = 0;
      while (sent < n_items / 2) begin
        kind   = $urandom_range(99);
        manual = 1'($urandom_range(1, 0));
        if (kind < 60) begin
          // low stretch that may trip the hold timer, then recovery
          len = $urandom_range(100, 1);
          repeat (len) send_tick(pick_mv(1'b1), manual, $urandom_range(29) == 0);
          sent += len;
          len = $urandom_range(40, 1);
          manual = 1'($urandom_range(1, 0));
          repeat (len) send_tick(pick_mv(1'b0), manual, 1'b0);
        end else if (kind < 75) begin
          send_tick(pick_mv(1'b0), manual, 1'b1);
          len = $urandom_range(40, 1);
          repeat (len) send_tick(pick_mv(1'b0), manual, 1'b0);
          sent += 1;
        end else begin
          len = $urandom_range(20, 1);
          repeat (len) send_tick(MvW'($urandom), 1'($urandom_range(1, 0)),
                                 $urandom_range(9) == 0);
        end
        sent += len;
      end
    end
  endtask

  // Largest and smallest register values
  task automatic test_extreme_settings();
    int unsigned i;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    wait_idle();
    write_reg(RegLowThreshold, 16'd16383);
    write_reg(RegLowHold, 16'hFFFF);
    write_reg(RegBeepHalf, 16'd32767);
    write_reg(RegToneDivide, 16'd15);
    write_reg(RegTicksPerMs, 16'd255);
    send_tick(14'd0, 1'b1, 1'b1);
    for (i = 0; i < 60; i++) send_tick(MvW'($urandom), 1'($urandom_range(1, 0)), 1'b0);
    wait_idle();
    write_reg(RegLowThreshold, 16'd0);
    write_reg(RegLowHold, 16'd0);
    write_reg(RegBeepHalf, 16'd1);
    write_reg(RegToneDivide, 16'd1);
    write_reg(RegTicksPerMs, 16'd1);
    for (i = 0; i < 50; i++)
      send_tick(MvW'($urandom), 1'($urandom_range(1, 0)), $urandom_range(4) == 0);
  endtask

  // Long result-side hold-off while ticks keep coming: input must stall
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    wait_idle();
    write_random_config();
    @(posedge clk_i);
    holdoff_req++;
    @(negedge clk_i);
    repeat (40) send_tick(pick_mv(1'($urandom_range(1, 0))), 1'($urandom_range(1, 0)),
                          $urandom_range(9) == 0);
  endtask

  // Test sequence
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_tone_and_pattern_corners();
    test_beep_half_zero();
    test_hold_saturation();
    test_random_phase(80, 0, 0);
    test_random_phase(60, 83, 0);
    test_random_phase(60, 0, 83);
    test_random_phase(60, 32, 32);
    test_extreme_settings();
    test_output_backpressure();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lbba_pkg.sv
rtl/low_battery_beep_alarm.sv
tb/tb_low_battery_beep_alarm.sv
